@@ src/kcld_pkg.sv @@
// ----------------------------------------------------------------------------
// kcld_pkg
// Shared types and constants for the key click / long-press detector.
// ----------------------------------------------------------------------------
package kcld_pkg;

  localparam int MAX_KEYS     = 4;
  localparam int NUM_KEYS_DEF = 4;
  localparam int CNT_W        = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  localparam logic [CNT_W-1:0] PRESS_COUNT_RST = 8'd3;
  localparam logic [CNT_W-1:0] LONG_COUNT_RST  = 8'd100;
  localparam logic [CNT_W-1:0] CNT_MAX         = 8'd255;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_LONG    = 3'd2,
    EV_CLICK   = 3'd3,
    EV_RELEASE = 3'd4
  } ev_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESS_COUNT    = 2'd0,
    REG_LONG_COUNT     = 2'd1,
    REG_EVENTS_ENABLED = 2'd2
  } cfg_idx_t;

  // thresholds shared by all lanes
  typedef struct packed {
    cnt_t press_count;
    cnt_t long_count;
  } thr_t;

endpackage

@@ src/kcld_lane.sv @@
// ----------------------------------------------------------------------------
// kcld_lane
// Per-key hold counter and event decision for one scan word.
// ----------------------------------------------------------------------------
module kcld_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              pressed,
  input  kcld_pkg::thr_t    thr,
  output kcld_pkg::ev_t     ev
);

  kcld_pkg::cnt_t cnt_r;
  kcld_pkg::cnt_t cnt_nxt;
  kcld_pkg::cnt_t cnt_inc;

  assign cnt_inc = (cnt_r == kcld_pkg::CNT_MAX) ? cnt_r : cnt_r + kcld_pkg::cnt_t'(1);

  // priority order: press equality first, then climb, then long equality
  always_comb begin
    cnt_nxt = cnt_r;
    ev      = kcld_pkg::EV_NONE;
    if (pressed) begin
      if (cnt_r == thr.press_count) begin
        cnt_nxt = cnt_inc;
        ev      = kcld_pkg::EV_PRESS;
      end else if (cnt_r < thr.long_count) begin
        cnt_nxt = cnt_inc;
      end else if (cnt_r == thr.long_count) begin
        cnt_nxt = cnt_inc;
        ev      = kcld_pkg::EV_LONG;
      end
    end else begin
      cnt_nxt = '0;
      if (cnt_r != '0) begin
        ev = (cnt_r < thr.long_count) ? kcld_pkg::EV_CLICK : kcld_pkg::EV_RELEASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ src/kcld_merge.sv @@
// ----------------------------------------------------------------------------
// kcld_merge
// Gathers lane events into one result word and holds it in the output
// register until taken.
// ----------------------------------------------------------------------------
module kcld_merge (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          events_enabled,
  input  kcld_pkg::ev_t lane_ev [kcld_pkg::MAX_KEYS],
  output logic          out_valid,
  input  logic          out_ready,
  output kcld_pkg::ev_t res_ev [kcld_pkg::MAX_KEYS]
);

  logic          out_valid_r;
  logic          fire;
  kcld_pkg::ev_t ev_r [kcld_pkg::MAX_KEYS];

  // output register empties or drains this cycle -> room for a new word
  assign in_ready  = !out_valid_r || out_ready;
  assign fire      = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int k = 0; k < kcld_pkg::MAX_KEYS; k++) begin
        ev_r[k] <= events_enabled ? lane_ev[k] : kcld_pkg::EV_NONE;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < kcld_pkg::MAX_KEYS; k++) begin
      res_ev[k] = ev_r[k];
    end
  end

endmodule

@@ src/key_click_longpress_detector.sv @@
// ----------------------------------------------------------------------------
// key_click_longpress_detector
// Top level: configuration registers, one lane per key, merge stage.
// ----------------------------------------------------------------------------
// Each accepted word is one scan tick of the raw key levels (low = pressed).
// Every key has its own lane with an 8-bit hold counter; all lanes update in
// the cycle the word is accepted and the merge stage registers the four event
// codes (0 none, 1 press, 2 long press, 3 click, 4 release). A word is taken
// every cycle unless the output register is full and stalled; its result is
// registered there and a new word enters in the same cycle the old one leaves.
// Configuration writes apply on the clock edge they are presented; events
// are forced to none while events_enabled is 0, counters still update.
// Keys at or beyond NUM_KEYS are ignored and always report none.
module key_click_longpress_detector #(
  parameter int NUM_KEYS = kcld_pkg::NUM_KEYS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [kcld_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kcld_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [kcld_pkg::MAX_KEYS-1:0]     in_key_levels,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_event_key0,
  output logic [2:0]                        out_event_key1,
  output logic [2:0]                        out_event_key2,
  output logic [2:0]                        out_event_key3
);

  kcld_pkg::thr_t thr_r;
  logic           events_enabled_r;
  logic           step;
  kcld_pkg::ev_t  lane_ev [kcld_pkg::MAX_KEYS];
  kcld_pkg::ev_t  res_ev  [kcld_pkg::MAX_KEYS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.press_count <= kcld_pkg::PRESS_COUNT_RST;
      thr_r.long_count  <= kcld_pkg::LONG_COUNT_RST;
      events_enabled_r  <= 1'b0;
    end else if (cfg_we) begin
      case (kcld_pkg::cfg_idx_t'(cfg_index))
        kcld_pkg::REG_PRESS_COUNT:    thr_r.press_count <= cfg_data;
        kcld_pkg::REG_LONG_COUNT:     thr_r.long_count  <= cfg_data;
        kcld_pkg::REG_EVENTS_ENABLED: events_enabled_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign step = in_valid && in_ready;

  for (genvar k = 0; k < kcld_pkg::MAX_KEYS; k++) begin : g_lane
    if (k < NUM_KEYS) begin : g_used
      kcld_lane u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .pressed (!in_key_levels[k]),
        .thr     (thr_r),
        .ev      (lane_ev[k])
      );
    end else begin : g_unused
      assign lane_ev[k] = kcld_pkg::EV_NONE;
    end
  end

  kcld_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .events_enabled (events_enabled_r),
    .lane_ev        (lane_ev),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .res_ev         (res_ev)
  );

  assign out_event_key0 = res_ev[0];
  assign out_event_key1 = res_ev[1];
  assign out_event_key2 = res_ev[2];
  assign out_event_key3 = res_ev[3];

endmodule
